@@ rtl/gpc_pkg.sv @@
package gpc_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 8'd1;

  localparam int DIM_BITS = 5;
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 5'd5;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 5'd5;

  // Reported column and row indexes are this wide.
  localparam int INDEX_OUT_BITS = 4;

  // Classification of one cell, made by the front and used by the back.
  typedef struct packed {
    logic blocked;
    logic left_edge;
    logic top_row;
    logic last;
  } cell_flags_t;

  localparam int FLAG_BITS = $bits(cell_flags_t);

endpackage

@@ rtl/gpc_ram.sv @@
module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/gpc_fifo.sv @@
module gpc_fifo #(
  parameter int WIDTH   = 8,
  parameter int DEPTH   = 2,
  parameter int RESERVE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PB = $clog2(DEPTH);
  localparam int LB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PB-1:0]    wptr;
  logic [PB-1:0]    rptr;
  logic [LB-1:0]    level;
  logic             do_push;
  logic             do_pop;

  // Full reports early by RESERVE entries so a writer may keep items in flight.
  assign full    = (level >= LB'(DEPTH - RESERVE));
  assign empty   = (level == '0);
  assign do_push = push && (level != LB'(DEPTH));
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PB'(DEPTH - 1)) ? '0 : wptr + PB'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PB'(DEPTH - 1)) ? '0 : rptr + PB'(1);
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + LB'(1);
        2'b01:   level <= level - LB'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/gpc_front.sv @@
module gpc_front #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 blocked,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gpc_pkg::DIM_BITS-1:0]         cfg_data,
  output logic                                 q_push,
  input  logic                                 q_full,
  output gpc_pkg::cell_flags_t                 q_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]         q_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]        q_row
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);

  logic [gpc_pkg::DIM_BITS-1:0] grid_width;
  logic [gpc_pkg::DIM_BITS-1:0] grid_height;
  logic [CB-1:0]                col;
  logic [RB-1:0]                row;
  logic [CB-1:0]                col_last;
  logic [RB-1:0]                row_last;
  logic                         accept;
  logic                         at_end;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign q_push    = accept;

  // Last usable column and row; zero acts as one and large values clamp.
  always_comb begin
    if (grid_width == '0) begin
      col_last = '0;
    end else if (int'(grid_width) > MAX_WIDTH) begin
      col_last = CB'(MAX_WIDTH - 1);
    end else begin
      col_last = CB'(grid_width - gpc_pkg::DIM_BITS'(1));
    end
    if (grid_height == '0) begin
      row_last = '0;
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      row_last = RB'(MAX_HEIGHT - 1);
    end else begin
      row_last = RB'(grid_height - gpc_pkg::DIM_BITS'(1));
    end
  end

  assign at_end = (col == col_last) && (row == row_last);

  always_comb begin
    q_flags.blocked   = blocked;
    q_flags.left_edge = (col == '0);
    q_flags.top_row   = (row == '0);
    q_flags.last      = at_end;
    q_col             = col;
    q_row             = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gpc_pkg::WIDTH_RESET;
      grid_height <= gpc_pkg::HEIGHT_RESET;
      col         <= '0;
      row         <= '0;
    end else if (cfg_valid && (cfg_index == gpc_pkg::REG_GRID_WIDTH)) begin
      grid_width <= cfg_data;
      col        <= '0;
      row        <= '0;
    end else if (cfg_valid && (cfg_index == gpc_pkg::REG_GRID_HEIGHT)) begin
      grid_height <= cfg_data;
      col         <= '0;
      row         <= '0;
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= at_end ? '0 : row + RB'(1);
      end else begin
        col <= col + CB'(1);
      end
    end
  end

endmodule

@@ rtl/gpc_back.sv @@
module gpc_back #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  output logic                                     q_pop,
  input  gpc_pkg::cell_flags_t                     q_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]             q_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]            q_row,
  output logic                                     empty,
  input  logic                                     pop,
  output logic [COUNT_BITS-1:0]                    path_count,
  output logic [gpc_pkg::INDEX_OUT_BITS-1:0]       column,
  output logic [gpc_pkg::INDEX_OUT_BITS-1:0]       row,
  output logic                                     last_cell
);

  localparam int CB        = $clog2(MAX_WIDTH);
  localparam int RB        = $clog2(MAX_HEIGHT);
  localparam int IB        = gpc_pkg::INDEX_OUT_BITS;
  localparam int OUT_W     = COUNT_BITS + 2 * IB + 1;
  localparam int OUT_DEPTH = 4;

  gpc_pkg::cell_flags_t  s1_flags;
  logic                  s1_valid;
  logic [CB-1:0]         s1_col;
  logic [RB-1:0]         s1_row;
  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] left_count;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] above;
  logic [COUNT_BITS-1:0] left;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] count;
  logic                  out_full;
  logic [OUT_W-1:0]      out_wdata;
  logic [OUT_W-1:0]      out_rdata;

  // The result queue reports full one entry early, so an item read from the
  // line buffer always finds room on the next cycle.
  assign q_pop = !q_empty && !out_full;

  gpc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(count),
    .raddr(q_col),
    .rdata(ram_rdata)
  );

  // A one-column grid reads the entry that the previous item writes in the
  // same cycle; that value is bypassed around the line buffer.
  always_comb begin
    above = s1_flags.top_row ? '0 : (fwd_hit ? fwd_data : ram_rdata);
    left  = s1_flags.left_edge ? '0 : left_count;
    sum   = {1'b0, left} + {1'b0, above};
    if (s1_flags.blocked) begin
      count = '0;
    end else if (s1_flags.left_edge && s1_flags.top_row) begin
      count = COUNT_BITS'(1);
    end else if (sum[COUNT_BITS]) begin
      count = '1;
    end else begin
      count = sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_flags <= q_flags;
      s1_col   <= q_col;
      s1_row   <= q_row;
      fwd_hit  <= s1_valid && (s1_col == q_col);
      fwd_data <= count;
    end
    if (s1_valid) begin
      left_count <= count;
    end
  end

  assign out_wdata = {count, IB'(s1_col), IB'(s1_row), s1_flags.last};

  gpc_fifo #(
    .WIDTH  (OUT_W),
    .DEPTH  (OUT_DEPTH),
    .RESERVE(1)
  ) u_out (
    .clk  (clk),
    .rst  (rst),
    .push (s1_valid),
    .pop  (pop),
    .wdata(out_wdata),
    .rdata(out_rdata),
    .full (out_full),
    .empty(empty)
  );

  assign path_count = out_rdata[OUT_W-1 -: COUNT_BITS];
  assign column     = out_rdata[2*IB -: IB];
  assign row        = out_rdata[IB -: IB];
  assign last_cell  = out_rdata[0];

endmodule

@@ rtl/grid_path_count_obstacles_top.sv @@
// Channel    Direction  Handshake            Payload
// input      in         push / full          blocked
// result     out        empty / pop          path_count, column, row, last_cell
// config     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One cell per clock is sustained while results are popped; an accepted item
// passes the cell queue, the line-buffer read and count, then the result queue.
// The rate is set by the single line-buffer read and saturating add per cell.
// Reset (rst, synchronous) sets both dimensions to 5 and restarts at cell (0,0).
// A stalled result side fills the result queue and then the cell queue, after
// which full rises; configuration writes are always taken.
module grid_path_count_obstacles_top #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                blocked,
  output logic                                empty,
  input  logic                                pop,
  output logic [COUNT_BITS-1:0]               path_count,
  output logic [gpc_pkg::INDEX_OUT_BITS-1:0]  column,
  output logic [gpc_pkg::INDEX_OUT_BITS-1:0]  row,
  output logic                                last_cell,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gpc_pkg::DIM_BITS-1:0]        cfg_data
);

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int FB    = gpc_pkg::FLAG_BITS;
  localparam int CMD_W = FB + CB + RB;

  gpc_pkg::cell_flags_t f_flags;
  gpc_pkg::cell_flags_t b_flags;
  logic [CB-1:0]        f_col;
  logic [RB-1:0]        f_row;
  logic [CB-1:0]        b_col;
  logic [RB-1:0]        b_row;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  logic [CMD_W-1:0]     q_wdata;
  logic [CMD_W-1:0]     q_rdata;

  gpc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .blocked  (blocked),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_flags  (f_flags),
    .q_col    (f_col),
    .q_row    (f_row)
  );

  assign q_wdata = {f_flags, f_col, f_row};

  gpc_fifo #(
    .WIDTH  (CMD_W),
    .DEPTH  (2),
    .RESERVE(0)
  ) u_cellq (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .wdata(q_wdata),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  assign b_flags = gpc_pkg::cell_flags_t'(q_rdata[CMD_W-1 -: FB]);
  assign b_col   = q_rdata[CB+RB-1 -: CB];
  assign b_row   = q_rdata[RB-1:0];

  gpc_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_flags   (b_flags),
    .q_col     (b_col),
    .q_row     (b_row),
    .empty     (empty),
    .pop       (pop),
    .path_count(path_count),
    .column    (column),
    .row       (row),
    .last_cell (last_cell)
  );

endmodule
